>>> rtl/core/bounded_deque_with_value_delete_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque core
// Clocked concurrent assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  `BDQ_ASSERT(lbl, (ante) |-> (cons), msg)

// A next-cycle implication checked outside reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `BDQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Widths, codes and shared types of the bounded deque core and its cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DataW       = 32;
  localparam int ModeW       = 3;
  localparam int StatusW     = 2;
  localparam int CountOutW   = 5;
  localparam int DefCapacity = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_DELETE     = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_TAKE_LEFT  = 3'd1,
    CELL_TAKE_RIGHT = 3'd2,
    CELL_LOAD_TAIL  = 3'd3,
    CELL_COMPARE    = 3'd4,
    CELL_DELETE     = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/core/bounded_deque_with_value_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with delete-by-value
// Ordered list of signed 32-bit entries held in a row of cells, front first.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low. Push front,
// push back, pop front, pop back and any unused mode give the result beat on the
// next cycle and a new command may be given at once. Delete by value has every
// cell compare its entry with the value, then, with busy high, the first-match
// chain picks the entry to remove and the cells behind it shift forward (but a
// match in the last entry and not the front one removes the last entry). A
// delete on an empty list skips the compare. The result beat is held for
// exactly one cycle with result_valid_o and the receiver cannot stall it.
// entry_count_o gives the count held after the command, modulo 32.
module bounded_deque_with_value_delete_core import bdq_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ModeW-1:0]          mode_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      result_valid_o,
  output logic [StatusW-1:0]        status_o,
  output logic signed [DataW-1:0]   removed_value_o,
  output logic [CountOutW-1:0]      entry_count_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DELETE = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             valid_q, valid_d;
  status_e          status_q, status_d;
  logic [DataW-1:0] removed_q, removed_d;
  logic [DataW-1:0] del_value_q, del_value_d;

  cell_ctrl_t       ctrl;
  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] tail_word [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] last_match_vec;
  logic [CAPACITY:0]   prefix;
  logic [DataW-1:0] tail_data;
  logic             accept;
  logic             full;
  logic             empty;
  logic             rear_hit;
  logic             found;
  logic [CntW+CountOutW-1:0] count_ext;

  assign accept = start & ~busy;
  assign busy   = state_q == ST_DELETE;
  assign full   = count_q == CntW'(CAPACITY);
  assign empty  = count_q == '0;

  assign prefix[0] = 1'b0;
  assign rear_hit  = |last_match_vec;
  assign found     = |match_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bdq_cell #(
      .INDEX(i),
      .CNT_W(CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_data_i ((i == 0) ? ctrl.value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data_i(cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .prefix_i    (prefix[i]),
      .prefix_o    (prefix[i+1]),
      .match_o     (match_vec[i]),
      .last_match_o(last_match_vec[i]),
      .data_o      (cell_data[i]),
      .tail_word_o (tail_word[i])
    );
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_data = tail_data | tail_word[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    removed_d   = removed_q;
    del_value_d = del_value_q;
    ctrl.op     = CELL_HOLD;
    ctrl.value  = value_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          valid_d   = 1'b1;
          status_d  = STATUS_OK;
          removed_d = '0;
          case (mode_i)
            MODE_PUSH_FRONT: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = CELL_TAKE_LEFT;
                count_d = count_q + 1'b1;
              end
            end
            MODE_PUSH_BACK: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = CELL_LOAD_TAIL;
                count_d = count_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op   = CELL_TAKE_RIGHT;
                removed_d = cell_data[0];
                count_d   = count_q - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                removed_d = tail_data;
                count_d   = count_q - 1'b1;
              end
            end
            MODE_DELETE: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                valid_d     = 1'b0;
                ctrl.op     = CELL_COMPARE;
                del_value_d = value_i;
                state_d     = ST_DELETE;
              end
            end
            default: begin
              status_d = STATUS_OK;
            end
          endcase
        end
      end
      ST_DELETE: begin
        state_d   = ST_IDLE;
        valid_d   = 1'b1;
        status_d  = STATUS_OK;
        removed_d = '0;
        if (rear_hit && !match_vec[0]) begin
          removed_d = del_value_q;
          count_d   = count_q - 1'b1;
        end else if (found) begin
          ctrl.op   = CELL_DELETE;
          removed_d = del_value_q;
          count_d   = count_q - 1'b1;
        end else begin
          status_d = STATUS_NOTFOUND;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    removed_q   <= removed_d;
    del_value_q <= del_value_d;
  end

  assign count_ext       = {{CountOutW{1'b0}}, count_q};
  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_ext[CountOutW-1:0];

endmodule

>>> rtl/core/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque cell
// Holds one entry of the list, shifts it to or from its neighbours, and keeps
// a match flag that feeds the first-match chain used by delete-by-value.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [DataW-1:0] left_data_i,
  input  logic [DataW-1:0] right_data_i,
  input  logic             prefix_i,
  output logic             prefix_o,
  output logic             match_o,
  output logic             last_match_o,
  output logic [DataW-1:0] data_o,
  output logic [DataW-1:0] tail_word_o
);

  localparam logic [CNT_W-1:0] Idx     = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IdxNext = CNT_W'(INDEX + 1);

  logic [DataW-1:0] data_q;
  logic             match_q;
  logic             occupied;
  logic             is_tail;
  logic             is_last;

  assign occupied = Idx < count_i;
  assign is_tail  = count_i == Idx;
  assign is_last  = count_i == IdxNext;

  assign prefix_o     = prefix_i | match_q;
  assign match_o      = match_q;
  assign last_match_o = match_q & is_last;
  assign data_o       = data_q;
  assign tail_word_o  = is_last ? data_q : '0;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_TAKE_LEFT:  data_q <= left_data_i;
      CELL_TAKE_RIGHT: data_q <= right_data_i;
      CELL_LOAD_TAIL: begin
        if (is_tail) begin
          data_q <= ctrl_i.value;
        end
      end
      CELL_DELETE: begin
        if (prefix_o) begin
          data_q <= right_data_i;
        end
      end
      default: data_q <= data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.op == CELL_COMPARE) begin
      match_q <= occupied && (data_q == ctrl_i.value);
    end
  end

endmodule

>>> rtl/core/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque checker
// Port-level assertions on the bounded deque core, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_value_delete_core_macros.svh"

module bdq_checker import bdq_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic [ModeW-1:0]        mode_i,
  input logic                    result_valid_o,
  input logic [StatusW-1:0]      status_o,
  input logic signed [DataW-1:0] removed_value_o,
  input logic [CountOutW-1:0]    entry_count_o
);

  `BDQ_ASSERT(a_count_bound, (CAPACITY > 31) || (entry_count_o <= CAPACITY), "count above capacity")

  `BDQ_ASSERT_NEXT(a_quick_result, start && !busy && (mode_i != MODE_DELETE), result_valid_o && !busy, "one-cycle command gave no beat")

  `BDQ_ASSERT_NEXT(a_delete_ends, busy, result_valid_o && !busy, "delete did not finish in two cycles")

  `BDQ_ASSERT_IMPL(a_no_removal, result_valid_o && (status_o != STATUS_OK), removed_value_o == 0, "failed command removed a value")

  `BDQ_ASSERT_IMPL(a_empty_count, result_valid_o && (status_o == STATUS_EMPTY), entry_count_o == 0, "empty status with entries held")

endmodule

bind bounded_deque_with_value_delete_core bdq_checker #(
  .CAPACITY(CAPACITY)
) u_bdq_checker (.*);
